// ----- rtl/core/oaid_pkg.sv -----
// Shared types, sizes and codes of the ordered array insert/delete block.
package oaid_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int CMD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int GROUP   = 8;
  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_POS   = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ----- rtl/core/oaid_cell.sv -----
// One slot of the list: holds a word and shifts, loads or holds each cycle.
module oaid_cell (
  input  logic                              clk_i,
  input  logic [oaid_pkg::IDX_W-1:0]        cell_idx_i,
  input  oaid_pkg::cell_ctl_t               ctl_i,
  input  logic [oaid_pkg::WORD_W-1:0]       left_i,
  input  logic [oaid_pkg::WORD_W-1:0]       right_i,
  output logic [oaid_pkg::WORD_W-1:0]       entry_o,
  output logic [oaid_pkg::WORD_W-1:0]       sel_word_o
);

  logic [oaid_pkg::WORD_W-1:0] entry_q, entry_d;
  logic                        hit, above;

  assign hit   = (cell_idx_i == ctl_i.idx);
  assign above = (cell_idx_i > ctl_i.idx);

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      oaid_pkg::OP_INS: begin
        if (hit) begin
          entry_d = ctl_i.value;
        end else if (above) begin
          entry_d = left_i;
        end
      end
      oaid_pkg::OP_DEL: begin
        if (hit || above) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // The word leaving the list on a delete; zero from every other cell.
  assign sel_word_o = (ctl_i.op == oaid_pkg::OP_DEL && hit) ? entry_q : '0;

endmodule

// ----- rtl/core/ordered_array_insert_delete.sv -----
// Top level of the ordered array list with insert and delete by position.
//
// Input channel (in_valid_i/in_ready_o) carries one command per transaction:
// cmd_i, value_i and position_i. Output channel (out_valid_o/out_ready_i)
// returns one result per command: status_o, removed_value_o and count_o.
// The list lives in a row of cells, one word per cell; every cell compares
// its own slot number with the target slot and shifts up, shifts down,
// loads or holds in the cycle the command is accepted.
// A result is registered in the gather stage and then in the output register.
// The removed word is gathered in two steps, an OR over groups of eight cells
// and then over the groups. One command per cycle while results are taken.
// Reset empties the list at once (the count goes to zero); the words
// themselves are not cleared and never read before written.
// When the receiver stalls, one result waits in the output register and one
// more in the gather stage; after that in_ready_o drops until a result is
// taken.
module ordered_array_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [oaid_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [oaid_pkg::WORD_W-1:0]  value_i,
  input  logic [oaid_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [oaid_pkg::WORD_W-1:0]  removed_value_o,
  output logic [oaid_pkg::COUNT_W-1:0]        count_o
);

  localparam int DEPTH = oaid_pkg::DEPTH;
  localparam int IDX_W = oaid_pkg::IDX_W;
  localparam int CNT_W = oaid_pkg::CNT_W;
  localparam int CMP_W = oaid_pkg::CMP_W;
  localparam int WW    = oaid_pkg::WORD_W;

  logic [CNT_W-1:0]        fill_q, fill_d;
  logic                    accept;
  logic                    full, empty, is_ins;
  logic [CMP_W-1:0]        fill_c, pos_c, pos_m1, fill_m1;
  oaid_pkg::status_e       status;
  oaid_pkg::cell_ctl_t     ctl;

  logic [WW-1:0]           entry    [DEPTH];
  logic [WW-1:0]           sel_word [DEPTH];
  logic [WW-1:0]           part_d   [oaid_pkg::NGROUPS];

  logic                    s1_valid_q;
  oaid_pkg::status_e       s1_status_q;
  logic [CNT_W-1:0]        s1_count_q;
  logic [WW-1:0]           s1_part_q [oaid_pkg::NGROUPS];
  logic [WW-1:0]           removed;
  logic                    out_load;

  assign accept = in_valid_i && in_ready_o;
  assign full   = (fill_q == CNT_W'(DEPTH));
  assign empty  = (fill_q == '0);
  assign fill_c  = CMP_W'(fill_q);
  assign pos_c   = CMP_W'(position_i);
  assign pos_m1  = pos_c - CMP_W'(1);
  assign fill_m1 = fill_c - CMP_W'(1);

  // Command decode: status and what the cell row does.
  always_comb begin
    status    = oaid_pkg::ST_OK;
    is_ins    = 1'b0;
    ctl.op    = oaid_pkg::OP_HOLD;
    ctl.idx   = '0;
    ctl.value = value_i;
    unique case (cmd_i)
      oaid_pkg::CMD_INS_FRONT: begin
        is_ins = 1'b1;
        if (full) status = oaid_pkg::ST_FULL;
        else      ctl.op = oaid_pkg::OP_INS;
      end
      oaid_pkg::CMD_INS_POS: begin
        is_ins  = 1'b1;
        ctl.idx = pos_m1[IDX_W-1:0];
        if (full) begin
          status = oaid_pkg::ST_FULL;
        end else if (pos_c == '0 || pos_c > fill_c + CMP_W'(1)) begin
          status = oaid_pkg::ST_RANGE;
        end else begin
          ctl.op = oaid_pkg::OP_INS;
        end
      end
      oaid_pkg::CMD_INS_END: begin
        is_ins  = 1'b1;
        ctl.idx = fill_c[IDX_W-1:0];
        if (full) status = oaid_pkg::ST_FULL;
        else      ctl.op = oaid_pkg::OP_INS;
      end
      oaid_pkg::CMD_DEL_FRONT: begin
        if (empty) status = oaid_pkg::ST_EMPTY;
        else       ctl.op = oaid_pkg::OP_DEL;
      end
      oaid_pkg::CMD_DEL_END: begin
        ctl.idx = fill_m1[IDX_W-1:0];
        if (empty) status = oaid_pkg::ST_EMPTY;
        else       ctl.op = oaid_pkg::OP_DEL;
      end
      oaid_pkg::CMD_DEL_POS: begin
        ctl.idx = pos_m1[IDX_W-1:0];
        if (empty) begin
          status = oaid_pkg::ST_EMPTY;
        end else if (pos_c == '0 || pos_c > fill_c) begin
          status = oaid_pkg::ST_RANGE;
        end else begin
          ctl.op = oaid_pkg::OP_DEL;
        end
      end
      default: status = oaid_pkg::ST_OK;
    endcase
    if (!accept) begin
      ctl.op = oaid_pkg::OP_HOLD;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ctl.op == oaid_pkg::OP_INS)      fill_d = fill_q + CNT_W'(1);
    else if (ctl.op == oaid_pkg::OP_DEL) fill_d = fill_q - CNT_W'(1);
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WW-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[k+1];
    end
    oaid_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(k)),
      .ctl_i      (ctl),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (entry[k]),
      .sel_word_o (sel_word[k])
    );
  end

  // First gather step: OR of the selected words within each group of cells.
  always_comb begin
    for (int g = 0; g < oaid_pkg::NGROUPS; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < oaid_pkg::GROUP; j++) begin
        if (g * oaid_pkg::GROUP + j < DEPTH) begin
          part_d[g] = part_d[g] | sel_word[g * oaid_pkg::GROUP + j];
        end
      end
    end
  end

  always_comb begin
    removed = '0;
    for (int g = 0; g < oaid_pkg::NGROUPS; g++) begin
      removed = removed | s1_part_q[g];
    end
  end

  assign out_load   = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (accept)        s1_valid_q <= 1'b1;
      else if (out_load) s1_valid_q <= 1'b0;
      if (out_load)         out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status;
      s1_count_q  <= fill_d;
      s1_part_q   <= part_d;
    end
    if (out_load) begin
      status_o        <= s1_status_q;
      removed_value_o <= removed;
      count_o         <= s1_count_q[oaid_pkg::COUNT_W-1:0];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_ins && full |=> s1_status_q == oaid_pkg::ST_FULL && $stable(fill_q))
    else $error("insert into full list not refused");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q == $past(fill_q) || fill_q == $past(fill_q) + CNT_W'(1) ||
             fill_q == $past(fill_q) - CNT_W'(1))
    else $error("fill count moved by more than one");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_value_o != '0 |-> status_o == oaid_pkg::ST_OK)
    else $error("removed word on a refused command");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("command taken while both result stages are held");

endmodule
